// ===== rtl/trcw_pkg.sv =====
// shared types, codes and constants of the reno congestion window engine
package trcw_pkg;

    // event codes carried in tuser
    typedef enum logic [2:0] {
        FUNC_NEW_ACK  = 3'd0,
        FUNC_DUP_ACK  = 3'd1,
        FUNC_TIMEOUT  = 3'd2,
        FUNC_RTT      = 3'd3,
        FUNC_RWND     = 3'd4,
        FUNC_RESTART  = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        PH_SLOW  = 2'd0,
        PH_AVOID = 2'd1,
        PH_RECOV = 2'd2
    } phase_t;

    // register indexes on the configuration port
    localparam logic [2:0] REG_INIT_CWND     = 3'd0;
    localparam logic [2:0] REG_INIT_SSTHRESH = 3'd1;
    localparam logic [2:0] REG_DEFAULT_RWND  = 3'd2;
    localparam logic [2:0] REG_INIT_TIMEOUT  = 3'd3;
    localparam logic [2:0] REG_MIN_TIMEOUT   = 3'd4;
    localparam logic [2:0] REG_MAX_TIMEOUT   = 3'd5;

    localparam int ADDR_W    = 5;
    localparam int SAMPLE_W  = 26;
    localparam int SRTT_W    = 29;
    localparam int DEV_W     = 28;

    localparam logic [7:0]  DUP_THRESHOLD = 8'd3;
    localparam logic [7:0]  DUP_MAX       = 8'd255;

    localparam logic [31:0] RST_INIT_CWND     = 32'd1;
    localparam logic [31:0] RST_INIT_SSTHRESH = 32'd65535;
    localparam logic [31:0] RST_DEFAULT_RWND  = 32'd65535;
    localparam logic [31:0] RST_INIT_TIMEOUT  = 32'd1000000;
    localparam logic [31:0] RST_MIN_TIMEOUT   = 32'd100000;
    localparam logic [31:0] RST_MAX_TIMEOUT   = 32'd60000000;

    typedef struct packed {
        logic [31:0] init_cwnd;
        logic [31:0] init_ssthresh;
        logic [31:0] default_rwnd;
        logic [31:0] init_timeout;
        logic [31:0] rto_floor;
        logic [31:0] rto_ceil;
    } cfg_t;

    typedef struct packed {
        logic [31:0]       window;
        logic [31:0]       threshold;
        logic [31:0]       recv_window;
        phase_t            phase;
        logic [7:0]        dup_acks;
        logic [31:0]       avoid_cnt;
        logic [SRTT_W-1:0] srtt;
        logic [DEV_W-1:0]  rttvar;
        logic [31:0]       rto;
    } cc_state_t;

    // saturating 32-bit add
    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// ===== rtl/trcw_cfg.sv =====
// apb configuration registers of the congestion window engine
module trcw_cfg
    import trcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_INIT_CWND:     cfg_next.init_cwnd     = pwdata;
                REG_INIT_SSTHRESH: cfg_next.init_ssthresh = pwdata;
                REG_DEFAULT_RWND:  cfg_next.default_rwnd  = pwdata;
                REG_INIT_TIMEOUT:  cfg_next.init_timeout  = pwdata;
                REG_MIN_TIMEOUT:   cfg_next.rto_floor     = pwdata;
                REG_MAX_TIMEOUT:   cfg_next.rto_ceil      = pwdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_INIT_CWND:     prdata = cfg_reg.init_cwnd;
            REG_INIT_SSTHRESH: prdata = cfg_reg.init_ssthresh;
            REG_DEFAULT_RWND:  prdata = cfg_reg.default_rwnd;
            REG_INIT_TIMEOUT:  prdata = cfg_reg.init_timeout;
            REG_MIN_TIMEOUT:   prdata = cfg_reg.rto_floor;
            REG_MAX_TIMEOUT:   prdata = cfg_reg.rto_ceil;
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.init_cwnd     <= RST_INIT_CWND;
            cfg_reg.init_ssthresh <= RST_INIT_SSTHRESH;
            cfg_reg.default_rwnd  <= RST_DEFAULT_RWND;
            cfg_reg.init_timeout  <= RST_INIT_TIMEOUT;
            cfg_reg.rto_floor     <= RST_MIN_TIMEOUT;
            cfg_reg.rto_ceil      <= RST_MAX_TIMEOUT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/trcw_calc.sv =====
// next state logic for one event: window, threshold, phase, dup count, receive window, rtt estimates and rto
module trcw_calc
    import trcw_pkg::*;
(
    input  cc_state_t           cur,
    input  cfg_t                cfg,
    input  func_t               func,
    input  logic [SAMPLE_W-1:0] rtt_sample_us,
    input  logic [31:0]         adv_rwnd,
    output cc_state_t           nxt,
    output logic [31:0]         effective_window
);

    logic [31:0]       win_inc;
    logic [31:0]       half_win;
    logic [31:0]       halved_thr;
    logic [31:0]       cnt_inc;
    logic [7:0]        dup_inc;
    logic [SRTT_W-1:0] s8;
    logic [SRTT_W-1:0] diff;
    logic [DEV_W:0]    dev_sum;
    logic [SRTT_W:0]   srtt_sum;
    logic [SRTT_W-1:0] srtt_new;
    logic [DEV_W-1:0]  dev_new;
    logic [SRTT_W-1:0] rto_raw;
    logic [31:0]       rto_hi;
    logic [31:0]       rto_clamp;

    assign win_inc    = sat_add32(cur.window, 32'd1);
    assign half_win   = {1'b0, cur.window[31:1]};
    assign halved_thr = (half_win < 32'd2) ? 32'd2 : half_win;
    assign cnt_inc    = sat_add32(cur.avoid_cnt, 32'd1);
    assign dup_inc    = (cur.dup_acks != DUP_MAX) ? cur.dup_acks + 8'd1 : cur.dup_acks;

    // rtt estimator, srtt has 3 fraction bits and rttvar 2
    assign s8   = {rtt_sample_us, 3'b000};
    assign diff = (s8 >= cur.srtt) ? s8 - cur.srtt : cur.srtt - s8;

    always_comb
    begin
        dev_sum  = {1'b0, cur.rttvar} - {3'b000, cur.rttvar[DEV_W-1:2]}
                   + {3'b000, diff[SRTT_W-1:3]};
        srtt_sum = {1'b0, cur.srtt} - {4'b0000, cur.srtt[SRTT_W-1:3]}
                   + {4'b0000, rtt_sample_us};
        if (cur.srtt == '0)
        begin
            srtt_new = s8;
            dev_new  = {1'b0, rtt_sample_us, 1'b0};
        end
        else
        begin
            srtt_new = srtt_sum[SRTT_W-1:0];
            dev_new  = dev_sum[DEV_W-1:0];
        end
        rto_raw   = {3'b000, srtt_new[SRTT_W-1:3]} + {1'b0, dev_new};
        rto_hi    = ({3'b000, rto_raw} > cfg.rto_ceil) ? cfg.rto_ceil
                                                        : {3'b000, rto_raw};
        rto_clamp = (rto_hi < cfg.rto_floor) ? cfg.rto_floor : rto_hi;
    end

    always_comb
    begin
        nxt = cur;
        case (func)
            FUNC_NEW_ACK:
            begin
                case (cur.phase)
                    PH_RECOV:
                    begin
                        nxt.window    = cur.threshold;
                        nxt.phase     = PH_AVOID;
                        nxt.avoid_cnt = 32'd0;
                    end
                    PH_AVOID:
                    begin
                        if (cnt_inc >= cur.window)
                        begin
                            nxt.window    = win_inc;
                            nxt.avoid_cnt = 32'd0;
                        end
                        else
                        begin
                            nxt.avoid_cnt = cnt_inc;
                        end
                    end
                    default:
                    begin
                        nxt.window = win_inc;
                        if (win_inc >= cur.threshold)
                        begin
                            nxt.phase     = PH_AVOID;
                            nxt.avoid_cnt = 32'd0;
                        end
                    end
                endcase
                nxt.dup_acks = 8'd0;
            end
            FUNC_DUP_ACK:
            begin
                nxt.dup_acks = dup_inc;
                if (dup_inc == DUP_THRESHOLD)
                begin
                    nxt.threshold = halved_thr;
                    nxt.window    = sat_add32(halved_thr, {24'd0, DUP_THRESHOLD});
                    nxt.phase     = PH_RECOV;
                end
                else if (dup_inc > DUP_THRESHOLD && cur.phase == PH_RECOV)
                begin
                    nxt.window = win_inc;
                end
            end
            FUNC_TIMEOUT:
            begin
                nxt.threshold = halved_thr;
                nxt.window    = 32'd1;
                nxt.phase     = PH_SLOW;
                nxt.dup_acks  = 8'd0;
                nxt.avoid_cnt = 32'd0;
                nxt.rto       = cur.rto[31] ? 32'hFFFF_FFFF : {cur.rto[30:0], 1'b0};
            end
            FUNC_RTT:
            begin
                nxt.srtt   = srtt_new;
                nxt.rttvar = dev_new;
                nxt.rto    = rto_clamp;
            end
            FUNC_RWND:
            begin
                nxt.recv_window = adv_rwnd;
            end
            FUNC_RESTART:
            begin
                nxt.window      = cfg.init_cwnd;
                nxt.threshold   = cfg.init_ssthresh;
                nxt.recv_window = cfg.default_rwnd;
                nxt.rto         = cfg.init_timeout;
                nxt.phase       = PH_SLOW;
                nxt.dup_acks    = 8'd0;
                nxt.avoid_cnt   = 32'd0;
                nxt.srtt        = '0;
                nxt.rttvar      = '0;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    assign effective_window = (nxt.window < nxt.recv_window) ? nxt.window : nxt.recv_window;

endmodule

// ===== rtl/tcp_reno_congestion_window_top.sv =====
// top level of the reno congestion window engine with rto estimator
// an input beat is held in the input register, then its result is registered in the result register on m_tvalid
// throughput: one event per cycle while m_tready is high; a single pass of calc logic sits
// between the input register and the result register, input stalls only when both are full
// reset (rst_n low, async): window 1, threshold and rwnd 65535, slow start,
// counts and rtt estimates zero, rto 1000000 us, registers back to defaults
module tcp_reno_congestion_window_top
    import trcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input event stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,   // [25:0] rtt_sample_us, [57:26] adv_rwnd, rest zero
    input  logic [2:0]        s_tuser,   // [2:0] func
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [143:0]      m_tdata,   // [31:0] cwnd_out, [63:32] ssthresh_out,
                                         // [95:64] effective_window, [97:96] phase,
                                         // [105:98] dup_count, [137:106] timeout_us, rest zero
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // input register stage
    logic                in_valid_reg;
    logic                in_valid_next;
    func_t               func_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [31:0]         rwnd_reg;

    // result register stage
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [143:0]        out_data_reg;

    // congestion state
    cc_state_t           state_reg;
    cc_state_t           state_next;
    cc_state_t           calc_state;
    logic [31:0]         calc_eff_win;
    cfg_t                cfg;

    logic                s_beat;
    logic                advance;

    // the input stage moves on whenever the result register is empty or being drained;
    // with a result held and the input register full the upstream side waits
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_beat   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    trcw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    trcw_calc u_calc (
        .cur              (state_reg),
        .cfg              (cfg),
        .func             (func_reg),
        .rtt_sample_us    (sample_reg),
        .adv_rwnd         (rwnd_reg),
        .nxt              (calc_state),
        .effective_window (calc_eff_win)
    );

    // state only commits when the event in the input register is handed on
    assign state_next = advance ? calc_state : state_reg;

    always_comb
    begin
        if (s_beat)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.window      <= 32'd1;
            state_reg.threshold   <= 32'd65535;
            state_reg.recv_window <= 32'd65535;
            state_reg.phase       <= PH_SLOW;
            state_reg.dup_acks    <= 8'd0;
            state_reg.avoid_cnt   <= 32'd0;
            state_reg.srtt        <= '0;
            state_reg.rttvar      <= '0;
            state_reg.rto         <= 32'd1000000;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            func_reg   <= func_t'(s_tuser);
            sample_reg <= s_tdata[SAMPLE_W-1:0];
            rwnd_reg   <= s_tdata[SAMPLE_W+31:SAMPLE_W];
        end
        if (advance)
        begin
            out_data_reg <= {6'd0,
                             calc_state.rto,
                             calc_state.dup_acks,
                             calc_state.phase,
                             calc_eff_win,
                             calc_state.threshold,
                             calc_state.window};
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench of the reno congestion window engine with its rto estimator
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import trcw_pkg::*;

    // event codes the block does not define, sent to check that they leave the state alone
    localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
    // register index past the end of the register map, writes there are dropped
    localparam logic [2:0] REG_SPARE_LO  = 3'd6;
    localparam logic [2:0] REG_SPARE_HI  = 3'd7;

    // watchdog bound, far above the length of a correct run
    localparam int CYCLE_LIMIT = 400000;

    // one result beat, declared msb first so that it overlays m_tdata[137:0]
    typedef struct packed {
        logic [31:0] timeout_us;
        logic [7:0]  dup_count;
        phase_t      phase;
        logic [31:0] eff_window;
        logic [31:0] ssthresh;
        logic [31:0] cwnd;
    } cc_report_t;

    // reno window and rto predictor plus the queue of reports it has promised
    class cwnd_scoreboard;
        logic [31:0]       cfg_cwnd, cfg_ssthresh, cfg_rwnd;
        logic [31:0]       cfg_rto, cfg_min_rto, cfg_max_rto;
        logic [31:0]       win, thresh, rwin, avoid_acks, rto;
        phase_t            ph;
        logic [7:0]        dups;
        logic [SRTT_W-1:0] srtt;
        logic [DEV_W-1:0]  rttvar;
        cc_report_t        promised[$];
        int                errors;

        function new();
            cfg_cwnd     = RST_INIT_CWND;
            cfg_ssthresh = RST_INIT_SSTHRESH;
            cfg_rwnd     = RST_DEFAULT_RWND;
            cfg_rto      = RST_INIT_TIMEOUT;
            cfg_min_rto  = RST_MIN_TIMEOUT;
            cfg_max_rto  = RST_MAX_TIMEOUT;
            win          = RST_INIT_CWND;
            thresh       = RST_INIT_SSTHRESH;
            rwin         = RST_DEFAULT_RWND;
            rto          = RST_INIT_TIMEOUT;
            clear_flow();
            errors       = 0;
        endfunction

        function void clear_flow();
            ph         = PH_SLOW;
            dups       = '0;
            avoid_acks = '0;
            srtt       = '0;
            rttvar     = '0;
        endfunction

        function logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function logic [31:0] half_window();
            return ((win >> 1) < 32'd2) ? 32'd2 : (win >> 1);
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_INIT_CWND:     cfg_cwnd     = val;
                REG_INIT_SSTHRESH: cfg_ssthresh = val;
                REG_DEFAULT_RWND:  cfg_rwnd     = val;
                REG_INIT_TIMEOUT:  cfg_rto      = val;
                REG_MIN_TIMEOUT:   cfg_min_rto  = val;
                REG_MAX_TIMEOUT:   cfg_max_rto  = val;
                default: ;
            endcase
        endfunction

        function void note_event(logic [2:0] code, logic [25:0] sample, logic [31:0] adv_rwnd);
            logic [31:0] s8, srtt32, diff, acc;
            cc_report_t  rep;
            case (code)
                FUNC_NEW_ACK:
                begin
                    if (ph == PH_RECOV)
                    begin
                        win        = thresh;
                        ph         = PH_AVOID;
                        avoid_acks = '0;
                    end
                    else if (ph == PH_AVOID)
                    begin
                        avoid_acks = add_clamped(avoid_acks, 32'd1);
                        if (avoid_acks >= win)
                        begin
                            win        = add_clamped(win, 32'd1);
                            avoid_acks = '0;
                        end
                    end
                    else
                    begin
                        win = add_clamped(win, 32'd1);
                        if (win >= thresh)
                        begin
                            ph         = PH_AVOID;
                            avoid_acks = '0;
                        end
                    end
                    dups = '0;
                end
                FUNC_DUP_ACK:
                begin
                    if (dups != DUP_MAX)
                        dups = dups + 8'd1;
                    if (dups == DUP_THRESHOLD)
                    begin
                        thresh = half_window();
                        win    = add_clamped(thresh, {24'd0, DUP_THRESHOLD});
                        ph     = PH_RECOV;
                    end
                    else if (dups > DUP_THRESHOLD && ph == PH_RECOV)
                    begin
                        win = add_clamped(win, 32'd1);
                    end
                end
                FUNC_TIMEOUT:
                begin
                    thresh     = half_window();
                    win        = 32'd1;
                    ph         = PH_SLOW;
                    dups       = '0;
                    avoid_acks = '0;
                    rto        = rto[31] ? 32'hFFFF_FFFF : {rto[30:0], 1'b0};
                end
                FUNC_RTT:
                begin
                    s8 = {3'b0, sample, 3'b0};
                    if (srtt == '0)
                    begin
                        // first sample seeds srtt with s and the deviation with s/2
                        srtt   = {sample, 3'b0};
                        rttvar = {1'b0, sample, 1'b0};
                    end
                    else
                    begin
                        srtt32 = {3'b0, srtt};
                        diff   = (s8 >= srtt32) ? s8 - srtt32 : srtt32 - s8;
                        acc    = {4'b0, rttvar} - ({4'b0, rttvar} >> 2) + (diff >> 3);
                        rttvar = acc[DEV_W-1:0];
                        acc    = srtt32 - (srtt32 >> 3) + {6'b0, sample};
                        srtt   = acc[SRTT_W-1:0];
                    end
                    acc = ({3'b0, srtt} >> 3) + {4'b0, rttvar};
                    if (acc > cfg_max_rto)
                        acc = cfg_max_rto;
                    if (acc < cfg_min_rto)
                        acc = cfg_min_rto;
                    rto = acc;
                end
                FUNC_RWND: rwin = adv_rwnd;
                FUNC_RESTART:
                begin
                    win    = cfg_cwnd;
                    thresh = cfg_ssthresh;
                    rwin   = cfg_rwnd;
                    rto    = cfg_rto;
                    clear_flow();
                end
                default: ;
            endcase
            rep.cwnd       = win;
            rep.ssthresh   = thresh;
            rep.eff_window = (win < rwin) ? win : rwin;
            rep.phase      = ph;
            rep.dup_count  = dups;
            rep.timeout_us = rto;
            promised.push_back(rep);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_report(logic [143:0] beat);
            cc_report_t got, want;
            got = beat[137:0];
            if (promised.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with no event pending, expected none, actual %h",
                         $time, beat);
                return;
            end
            want = promised.pop_front();
            check_field("cwnd_out", want.cwnd, got.cwnd);
            check_field("ssthresh_out", want.ssthresh, got.ssthresh);
            check_field("effective_window", want.eff_window, got.eff_window);
            check_field("phase", {30'd0, want.phase}, {30'd0, got.phase});
            check_field("dup_count", {24'd0, want.dup_count}, {24'd0, got.dup_count});
            check_field("timeout_us", want.timeout_us, got.timeout_us);
        endfunction

        function int pending();
            return promised.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [63:0]       s_tdata;   // [25:0] rtt_sample_us, [57:26] adv_rwnd, rest zero
    logic [2:0]        s_tuser;   // [2:0] func
    logic              m_tvalid;
    logic              m_tready;
    logic [143:0]      m_tdata;   // [31:0] cwnd_out, [63:32] ssthresh_out,
                                  // [95:64] effective_window, [97:96] phase,
                                  // [105:98] dup_count, [137:106] timeout_us, rest zero
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    cwnd_scoreboard sb;

    // idle odds in percent for each side, and a long receiver hold-off counted in cycles
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    tcp_reno_congestion_window_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hang anywhere ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: check every accepted beat, then decide the next tready
    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (m_tvalid && m_tready)
                sb.check_report(m_tdata);
            if (hold_left > 0)
            begin
                // long stall so that the block backs up into its input
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
            @(posedge clk);
        end
    end

    // apb write with a setup phase and an access phase, then psel is dropped and the bus left idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    // offer one event beat, keep tvalid high across back-to-back beats
    task automatic send_event(input logic [2:0] code, input logic [25:0] sample,
                              input logic [31:0] adv_rwnd);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= code;
        s_tdata  <= {6'b0, adv_rwnd, sample};
        do @(posedge clk); while (!s_tready);
        sb.note_event(code, sample, adv_rwnd);
    endtask

    // drop tvalid and let every promised report come back before touching registers
    task automatic drain_events();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_all_regs(input logic [31:0] cwnd, input logic [31:0] ssthresh,
                                  input logic [31:0] rwnd, input logic [31:0] rto0,
                                  input logic [31:0] rto_lo, input logic [31:0] rto_hi);
        write_reg(REG_INIT_CWND, cwnd);
        write_reg(REG_INIT_SSTHRESH, ssthresh);
        write_reg(REG_DEFAULT_RWND, rwnd);
        write_reg(REG_INIT_TIMEOUT, rto0);
        write_reg(REG_MIN_TIMEOUT, rto_lo);
        write_reg(REG_MAX_TIMEOUT, rto_hi);
    endtask

    // mostly ack traffic with dup bursts so the window walks through all three phases;
    // restarts and timeouts keep the window small enough for avoidance to grow it
    task automatic send_random_events(input int count);
        int          sent, pick, burst;
        logic [25:0] sample;
        logic [31:0] rw;
        sent = 0;
        while (sent < count)
        begin
            pick   = $urandom_range(0, 99);
            sample = 26'($urandom);
            rw     = $urandom;
            if (pick < 40)
            begin
                send_event(FUNC_NEW_ACK, sample, rw);
                sent++;
            end
            else if (pick < 62)
            begin
                // short run of duplicates, often long enough to enter fast recovery
                burst = $urandom_range(1, 6);
                repeat (burst) send_event(FUNC_DUP_ACK, 26'($urandom), $urandom);
                sent += burst;
            end
            else
            begin
                if (pick < 72)
                begin
                    case ($urandom_range(0, 7)) inside
                        0:       sample = '0;
                        [1:2]:   sample = 26'($urandom);
                        default: sample = 26'($urandom_range(1, 200000));
                    endcase
                    send_event(FUNC_RTT, sample, rw);
                end
                else if (pick < 80)
                    send_event(FUNC_TIMEOUT, sample, rw);
                else if (pick < 88)
                    send_event(FUNC_RWND, sample,
                               $urandom_range(0, 1) ? $urandom : $urandom_range(0, 64));
                else if (pick < 95)
                    send_event(FUNC_RESTART, sample, rw);
                else
                    send_event($urandom_range(0, 1) ? FUNC_SPARE_LO : FUNC_SPARE_HI,
                               sample, rw);
                sent++;
            end
        end
    endtask

    initial
    begin
        sb = new();
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset defaults, slow start, fast recovery entry and growth,
        // recovery exit into avoidance, one avoidance step
        send_event(FUNC_NEW_ACK, '0, '0);
        repeat (4) send_event(FUNC_DUP_ACK, '0, '0);
        repeat (3) send_event(FUNC_NEW_ACK, '0, '0);
        // zero sample stays "first", then the largest sample, then an ordinary one
        send_event(FUNC_RTT, '0, '0);
        send_event(FUNC_RTT, '1, '0);
        send_event(FUNC_RTT, 26'd1000, '0);
        // receive window extremes
        send_event(FUNC_RWND, '0, '0);
        send_event(FUNC_RWND, '0, '1);
        send_event(FUNC_TIMEOUT, '0, '0);
        send_event(FUNC_SPARE_LO, '1, '1);
        send_event(FUNC_SPARE_HI, '1, '1);
        send_event(FUNC_RESTART, '0, '0);
        drain_events();

        // directed: saturating window and timer, crossed rto clamps
        write_all_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd65535, 32'hFFFF_FFFF,
                       32'd200000, 32'd50000);
        send_event(FUNC_RESTART, '0, '0);
        send_event(FUNC_NEW_ACK, '0, '0);
        send_event(FUNC_TIMEOUT, '0, '0);
        send_event(FUNC_RTT, 26'd5000, '0);
        send_event(FUNC_RESTART, '0, '0);
        repeat (3) send_event(FUNC_DUP_ACK, '0, '0);
        drain_events();

        // random 1: small threshold, wide clamps, slow receiver with a long hold-off
        write_all_regs(32'd1, 32'd8, 32'd20, 32'd3000000, 32'd0, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'h1234_5678);
        send_idle_pct = 34;
        recv_idle_pct = 82;
        hold_left     = 300;
        send_event(FUNC_RESTART, '0, '0);
        send_random_events(610);
        drain_events();

        // random 2: smallest threshold and timer, zero receive window, slow sender
        write_all_regs(32'd3, 32'd2, 32'd0, 32'd1, 32'd100, 32'd200000);
        send_idle_pct = 82;
        recv_idle_pct = 34;
        send_event(FUNC_RESTART, '0, '0);
        send_random_events(610);
        drain_events();

        // random 3: crossed clamps at zero, top half timer, no idling at all
        write_all_regs(32'd10, 32'd40, 32'hFFFF_FFFF, 32'h8000_0000, 32'd300, 32'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_event(FUNC_RESTART, '0, '0);
        // a long duplicate run to saturate the duplicate counter
        repeat (260) send_event(FUNC_DUP_ACK, 26'($urandom), $urandom);
        send_random_events(350);
        drain_events();
        repeat (10) @(posedge clk);

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/trcw_pkg.sv
rtl/trcw_cfg.sv
rtl/trcw_calc.sv
rtl/tcp_reno_congestion_window_top.sv
tb/tb_top.sv
